>>> rtl/core/cyr_pkg.sv
package cyr_pkg;

    localparam int MAX_DIM_DEF = 4096;
    localparam int Q_DEPTH_DEF = 4;

    localparam int PIX_W      = 8;
    localparam int DIM_REG_W  = 13;
    localparam int OFF_REG_W  = 10;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 13;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PIC_WIDTH   = 8'd0,
        REG_PIC_HEIGHT  = 8'd1,
        REG_CROP_LEFT   = 8'd2,
        REG_CROP_RIGHT  = 8'd3,
        REG_CROP_TOP    = 8'd4,
        REG_CROP_BOTTOM = 8'd5,
        REG_VERT_FOUR   = 8'd6,
        REG_RGB_MODE    = 8'd7
    } t_reg_idx;

    // kept pixel on its way from front to back
    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] chroma_red;
        logic             frame_last;
    } t_item;

endpackage

>>> rtl/core/cyr_if.sv
interface cyr_pix_in_if;
    import cyr_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] luma;
    logic [PIX_W-1:0] chroma_blue;
    logic [PIX_W-1:0] chroma_red;
    modport source (output valid, output luma, output chroma_blue, output chroma_red,
                    input ready);
    modport sink (input valid, input luma, input chroma_blue, input chroma_red,
                  output ready);
endinterface

interface cyr_pix_out_if;
    import cyr_pkg::*;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] comp0;
    logic [PIX_W-1:0] comp1;
    logic [PIX_W-1:0] comp2;
    logic             frame_last;
    modport source (output valid, output comp0, output comp1, output comp2,
                    output frame_last, input ready);
    modport sink (input valid, input comp0, input comp1, input comp2,
                  input frame_last, output ready);
endinterface

interface cyr_cfg_if;
    import cyr_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/core/cyr_front.sv
module cyr_front #(
    parameter int MAX_DIM = cyr_pkg::MAX_DIM_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    cyr_cfg_if.sink        i_cfg,
    cyr_pix_in_if.sink     i_pix,
    input  logic           i_q_ready,
    output logic           o_push,
    output cyr_pkg::t_item o_push_item,
    output logic           o_rgb_mode
);
    import cyr_pkg::*;

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM + 1);
    localparam int LW = (DW > DIM_REG_W) ? DW : DIM_REG_W;
    localparam int AW = ((DW > 12) ? DW : 12) + 1;

    logic [DIM_REG_W-1:0] r_pic_width;
    logic [DIM_REG_W-1:0] r_pic_height;
    logic [OFF_REG_W-1:0] r_crop_left;
    logic [OFF_REG_W-1:0] r_crop_right;
    logic [OFF_REG_W-1:0] r_crop_top;
    logic [OFF_REG_W-1:0] r_crop_bottom;
    logic                 r_vert_four;
    logic                 r_rgb_mode;

    logic [CW-1:0] r_col;
    logic [CW-1:0] r_row;
    logic [CW-1:0] n_col;
    logic [CW-1:0] n_row;

    logic [DW-1:0] w_lim;
    logic [DW-1:0] h_lim;
    logic [AW-1:0] left2;
    logic [AW-1:0] right2;
    logic [AW-1:0] top_m;
    logic [AW-1:0] bottom_m;
    logic [AW-1:0] col_x;
    logic [AW-1:0] row_x;
    logic [AW-1:0] col_end;
    logic [AW-1:0] row_end;
    logic [AW-1:0] col_inc;
    logic [AW-1:0] row_inc;
    logic          kept;
    logic          accept;

    function automatic logic [DW-1:0] limit_dim(input logic [DIM_REG_W-1:0] v);
        logic [LW-1:0] ve;
        logic [DW-1:0] r;
        ve = LW'(v);
        if (ve == '0) begin
            r = DW'(1);
        end else if (ve > LW'(MAX_DIM)) begin
            r = DW'(MAX_DIM);
        end else begin
            r = DW'(ve);
        end
        return r;
    endfunction

    assign i_cfg.ready = 1'b1;
    assign i_pix.ready = i_q_ready;
    assign accept      = i_pix.valid && i_q_ready;
    assign o_rgb_mode  = r_rgb_mode;

    always_comb begin
        w_lim    = limit_dim(r_pic_width);
        h_lim    = limit_dim(r_pic_height);
        left2    = AW'({r_crop_left, 1'b0});
        right2   = AW'({r_crop_right, 1'b0});
        top_m    = r_vert_four ? AW'({r_crop_top, 2'b00}) : AW'({r_crop_top, 1'b0});
        bottom_m = r_vert_four ? AW'({r_crop_bottom, 2'b00}) : AW'({r_crop_bottom, 1'b0});
        col_x    = AW'(r_col);
        row_x    = AW'(r_row);
        col_end  = col_x + right2;
        row_end  = row_x + bottom_m;
        kept     = (col_x >= left2) && (col_end < AW'(w_lim)) &&
                   (row_x >= top_m) && (row_end < AW'(h_lim));
        col_inc  = col_x + AW'(1);
        row_inc  = row_x + AW'(1);
        n_col    = r_col;
        n_row    = r_row;
        if (col_inc >= AW'(w_lim)) begin
            n_col = '0;
            n_row = (row_inc >= AW'(h_lim)) ? '0 : CW'(row_inc);
        end else begin
            n_col = CW'(col_inc);
        end
    end

    assign o_push                  = accept && kept;
    assign o_push_item.luma        = i_pix.luma;
    assign o_push_item.chroma_blue = i_pix.chroma_blue;
    assign o_push_item.chroma_red  = i_pix.chroma_red;
    assign o_push_item.frame_last  = (col_end + AW'(1) == AW'(w_lim)) &&
                                     (row_end + AW'(1) == AW'(h_lim));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pic_width   <= DIM_REG_W'(16);
            r_pic_height  <= DIM_REG_W'(16);
            r_crop_left   <= '0;
            r_crop_right  <= '0;
            r_crop_top    <= '0;
            r_crop_bottom <= '0;
            r_vert_four   <= 1'b0;
            r_rgb_mode    <= 1'b1;
            r_col         <= '0;
            r_row         <= '0;
        end else begin
            if (i_cfg.valid) begin
                unique case (t_reg_idx'(i_cfg.index))
                    REG_PIC_WIDTH:   r_pic_width   <= i_cfg.data;
                    REG_PIC_HEIGHT:  r_pic_height  <= i_cfg.data;
                    REG_CROP_LEFT:   r_crop_left   <= i_cfg.data[OFF_REG_W-1:0];
                    REG_CROP_RIGHT:  r_crop_right  <= i_cfg.data[OFF_REG_W-1:0];
                    REG_CROP_TOP:    r_crop_top    <= i_cfg.data[OFF_REG_W-1:0];
                    REG_CROP_BOTTOM: r_crop_bottom <= i_cfg.data[OFF_REG_W-1:0];
                    REG_VERT_FOUR:   r_vert_four   <= i_cfg.data[0];
                    REG_RGB_MODE:    r_rgb_mode    <= i_cfg.data[0];
                    default: begin
                    end
                endcase
            end
            if (accept) begin
                r_col <= n_col;
                r_row <= n_row;
            end
        end
    end

endmodule

>>> rtl/core/cyr_fifo.sv
module cyr_fifo #(
    parameter int DEPTH = cyr_pkg::Q_DEPTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cyr_pkg::t_item i_item,
    output logic           o_ready,
    output logic           o_valid,
    output cyr_pkg::t_item o_item,
    input  logic           i_pop
);
    import cyr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    t_item         r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [NW-1:0] r_count;
    logic          push;
    logic          pop;

    assign o_ready = (r_count != NW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd];
    assign push    = i_push && o_ready;
    assign pop     = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + NW'(1);
                2'b01:   r_count <= r_count - NW'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/core/cyr_back.sv
module cyr_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  cyr_pkg::t_item i_item,
    output logic           o_ready,
    input  logic           i_rgb_mode,
    cyr_pix_out_if.source  o_pix
);
    import cyr_pkg::*;

    localparam int PROD_W = 19;
    localparam int SUM_W  = 20;

    localparam logic signed [PROD_W-1:0] C_Y  = 19'sd298;
    localparam logic signed [PROD_W-1:0] C_RV = 19'sd409;
    localparam logic signed [PROD_W-1:0] C_GU = 19'sd100;
    localparam logic signed [PROD_W-1:0] C_GV = 19'sd208;
    localparam logic signed [PROD_W-1:0] C_BU = 19'sd516;

    logic signed [8:0] y_s;
    logic signed [8:0] u_s;
    logic signed [8:0] v_s;

    logic                     r_s1_valid;
    t_item                    r_s1_item;
    logic signed [PROD_W-1:0] r_py;
    logic signed [PROD_W-1:0] r_prv;
    logic signed [PROD_W-1:0] r_pgu;
    logic signed [PROD_W-1:0] r_pgv;
    logic signed [PROD_W-1:0] r_pbu;

    logic signed [SUM_W-1:0] sum_r;
    logic signed [SUM_W-1:0] sum_g;
    logic signed [SUM_W-1:0] sum_b;

    logic             r_s2_valid;
    logic [PIX_W-1:0] r_c0;
    logic [PIX_W-1:0] r_c1;
    logic [PIX_W-1:0] r_c2;
    logic             r_last;

    logic s1_ready;
    logic s2_ready;

    function automatic logic [PIX_W-1:0] q8_clamp(input logic signed [SUM_W-1:0] s);
        logic [PIX_W-1:0] r;
        if (s[SUM_W-1]) begin
            r = '0;
        end else if (|s[SUM_W-2:16]) begin
            r = '1;
        end else begin
            r = s[15:8];
        end
        return r;
    endfunction

    assign s2_ready = !r_s2_valid || o_pix.ready;
    assign s1_ready = !r_s1_valid || s2_ready;
    assign o_ready  = s1_ready;

    assign y_s = signed'({1'b0, i_item.luma}) - 9'sd16;
    assign u_s = signed'({1'b0, i_item.chroma_blue}) - 9'sd128;
    assign v_s = signed'({1'b0, i_item.chroma_red}) - 9'sd128;

    assign sum_r = SUM_W'(r_py) + SUM_W'(r_prv);
    assign sum_g = SUM_W'(r_py) - SUM_W'(r_pgu) - SUM_W'(r_pgv);
    assign sum_b = SUM_W'(r_py) + SUM_W'(r_pbu);

    // multiply stage
    always_ff @(posedge i_clk) begin
        if (s1_ready && i_valid) begin
            r_s1_item <= i_item;
            r_py      <= PROD_W'(y_s) * C_Y;
            r_prv     <= PROD_W'(v_s) * C_RV;
            r_pgu     <= PROD_W'(u_s) * C_GU;
            r_pgv     <= PROD_W'(v_s) * C_GV;
            r_pbu     <= PROD_W'(u_s) * C_BU;
        end
    end

    // sum, clamp and output register, or pass-through of the raw components
    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_last <= r_s1_item.frame_last;
            if (i_rgb_mode) begin
                r_c0 <= q8_clamp(sum_r);
                r_c1 <= q8_clamp(sum_g);
                r_c2 <= q8_clamp(sum_b);
            end else begin
                r_c0 <= r_s1_item.chroma_red;
                r_c1 <= r_s1_item.luma;
                r_c2 <= r_s1_item.chroma_blue;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
        end else begin
            if (s1_ready) begin
                r_s1_valid <= i_valid;
            end
            if (s2_ready) begin
                r_s2_valid <= r_s1_valid;
            end
        end
    end

    assign o_pix.valid      = r_s2_valid;
    assign o_pix.comp0      = r_c0;
    assign o_pix.comp1      = r_c1;
    assign o_pix.comp2      = r_c2;
    assign o_pix.frame_last = r_last;

endmodule

>>> rtl/core/crop_and_ycbcr_to_rgb.sv
// a kept item passes the queue, the multiply stage and the output register on its way out
// throughput: one item per cycle while the queue is not full; dropped items give no result
// a Q_DEPTH-entry queue, four by default, parts the crop front from the two-stage conversion back
// synchronous active-low reset clears raster counters, queue and stage valids
// and restores the register defaults
module crop_and_ycbcr_to_rgb #(
    parameter int MAX_DIM = cyr_pkg::MAX_DIM_DEF,
    parameter int Q_DEPTH = cyr_pkg::Q_DEPTH_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    cyr_cfg_if.sink       i_cfg,
    cyr_pix_in_if.sink    i_pix,
    cyr_pix_out_if.source o_pix
);
    import cyr_pkg::*;

    logic  push;
    t_item push_item;
    logic  q_ready;
    logic  q_valid;
    t_item q_item;
    logic  back_ready;
    logic  rgb_mode;

    cyr_front #(
        .MAX_DIM (MAX_DIM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (i_cfg),
        .i_pix       (i_pix),
        .i_q_ready   (q_ready),
        .o_push      (push),
        .o_push_item (push_item),
        .o_rgb_mode  (rgb_mode)
    );

    cyr_fifo #(
        .DEPTH (Q_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (back_ready)
    );

    cyr_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (q_valid),
        .i_item     (q_item),
        .o_ready    (back_ready),
        .i_rgb_mode (rgb_mode),
        .o_pix      (o_pix)
    );

endmodule

>>> rtl/core/cyr_checker.sv
module cyr_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_comp0,
    input logic [7:0] i_out_comp1,
    input logic [7:0] i_out_comp2,
    input logic       i_out_last
);

    // a stalled item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_comp0) &&
        $stable(i_out_comp1) && $stable(i_out_comp2) && $stable(i_out_last))
        else $error("output item changed while stalled");

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("output valid after reset");

    // input side only backs up when the output side is stalled
    a_ready_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(i_in_ready) && $past(i_rst_n) |-> $past(i_out_valid && !i_out_ready))
        else $error("input ready dropped without output stall");

endmodule

bind crop_and_ycbcr_to_rgb cyr_checker u_cyr_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_pix.ready),
    .i_out_valid (o_pix.valid),
    .i_out_ready (o_pix.ready),
    .i_out_comp0 (o_pix.comp0),
    .i_out_comp1 (o_pix.comp1),
    .i_out_comp2 (o_pix.comp2),
    .i_out_last  (o_pix.frame_last)
);

>>> tb/testbench.sv
module testbench;
    import cyr_pkg::*;

    localparam int CYCLE_LIMIT = 600000;
    localparam int SETTLE      = 2 + Q_DEPTH_DEF + 4;
    localparam int HOLD_LEN    = 60;
    localparam int RAND_ITEMS  = 50;
    localparam int SWEEP_ITEMS = 40;
    localparam int N_PHASES    = 8;
    localparam int MAX_PRINTS  = 100;
    localparam int N_STEPS     = 32;

    // index past the register list, writes to it must be ignored
    localparam logic [CFG_IDX_W-1:0] REG_NONE = 8'd200;

    typedef enum logic { ROW_PX, ROW_WR } t_row_kind;
    typedef enum logic [1:0] { CHK_PRED, CHK_GIVEN, CHK_DROP } t_check;

    typedef struct packed {
        logic [PIX_W-1:0] luma;
        logic [PIX_W-1:0] chroma_blue;
        logic [PIX_W-1:0] chroma_red;
    } t_sample;

    typedef struct packed {
        logic [PIX_W-1:0] comp0;
        logic [PIX_W-1:0] comp1;
        logic [PIX_W-1:0] comp2;
        logic             frame_last;
    } t_rgb;

    typedef struct packed {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] val;
        logic [PIX_W-1:0]      luma;
        logic [PIX_W-1:0]      cb;
        logic [PIX_W-1:0]      cr;
        t_check                chk;
        logic [PIX_W-1:0]      c0;
        logic [PIX_W-1:0]      c1;
        logic [PIX_W-1:0]      c2;
        logic                  fl;
    } t_step;

    localparam t_step DIRECTED [N_STEPS] = '{
        '{ROW_PX, REG_NONE, 13'h0, 8'h10, 8'h80, 8'h80, CHK_GIVEN, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_PX, REG_NONE, 13'h0, 8'hFF, 8'h80, 8'h80, CHK_GIVEN, 8'hFF, 8'hFF, 8'hFF, 1'b0},
        '{ROW_PX, REG_NONE, 13'h0, 8'hEB, 8'h80, 8'h80, CHK_GIVEN, 8'hFE, 8'hFE, 8'hFE, 1'b0},
        '{ROW_PX, REG_NONE, 13'h0, 8'h0, 8'h0, 8'h0, CHK_PRED, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_PX, REG_NONE, 13'h0, 8'hFF, 8'hFF, 8'hFF, CHK_PRED, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_PX, REG_NONE, 13'h0, 8'h0, 8'hFF, 8'h0, CHK_PRED, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_PX, REG_NONE, 13'h0, 8'hFF, 8'h0, 8'hFF, CHK_PRED, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_WR, REG_RGB_MODE, 13'h0, 8'h0, 8'h0, 8'h0, CHK_DROP, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_PX, REG_NONE, 13'h0, 8'hA5, 8'h5A, 8'hC3, CHK_GIVEN, 8'hC3, 8'hA5, 8'h5A, 1'b0},
        '{ROW_PX, REG_NONE, 13'h0, 8'h5A, 8'hA5, 8'h3C, CHK_GIVEN, 8'h3C, 8'h5A, 8'hA5, 1'b0},
        // shrink the width while the column counter is past it
        '{ROW_WR, REG_PIC_WIDTH, 13'h4, 8'h0, 8'h0, 8'h0, CHK_DROP, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_PX, REG_NONE, 13'h0, 8'h33, 8'h44, 8'h55, CHK_DROP, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_WR, REG_PIC_HEIGHT, 13'h2, 8'h0, 8'h0, 8'h0, CHK_DROP, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_WR, REG_NONE, 13'h1, 8'h0, 8'h0, 8'h0, CHK_DROP, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_PX, REG_NONE, 13'h0, 8'h01, 8'h02, 8'h03, CHK_GIVEN, 8'h03, 8'h01, 8'h02, 1'b0},
        '{ROW_PX, REG_NONE, 13'h0, 8'h04, 8'h05, 8'h06, CHK_GIVEN, 8'h06, 8'h04, 8'h05, 1'b0},
        '{ROW_PX, REG_NONE, 13'h0, 8'h07, 8'h08, 8'h09, CHK_GIVEN, 8'h09, 8'h07, 8'h08, 1'b0},
        '{ROW_PX, REG_NONE, 13'h0, 8'h0A, 8'h0B, 8'h0C, CHK_GIVEN, 8'h0C, 8'h0A, 8'h0B, 1'b1},
        // window with no pixel in it
        '{ROW_WR, REG_CROP_LEFT, 13'h1, 8'h0, 8'h0, 8'h0, CHK_DROP, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_WR, REG_CROP_RIGHT, 13'h1, 8'h0, 8'h0, 8'h0, CHK_DROP, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_PX, REG_NONE, 13'h0, 8'h11, 8'h22, 8'h33, CHK_DROP, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_PX, REG_NONE, 13'h0, 8'h44, 8'h55, 8'h66, CHK_DROP, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_PX, REG_NONE, 13'h0, 8'h77, 8'h88, 8'h99, CHK_DROP, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_PX, REG_NONE, 13'h0, 8'hAA, 8'hBB, 8'hCC, CHK_DROP, 8'h0, 8'h0, 8'h0, 1'b0},
        // zero width acts as one column, oversized height as the maximum
        '{ROW_WR, REG_PIC_WIDTH, 13'h0, 8'h0, 8'h0, 8'h0, CHK_DROP, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_WR, REG_CROP_LEFT, 13'h0, 8'h0, 8'h0, 8'h0, CHK_DROP, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_WR, REG_CROP_RIGHT, 13'h0, 8'h0, 8'h0, 8'h0, CHK_DROP, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_WR, REG_RGB_MODE, 13'h1, 8'h0, 8'h0, 8'h0, CHK_DROP, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_PX, REG_NONE, 13'h0, 8'h10, 8'h80, 8'h80, CHK_GIVEN, 8'h0, 8'h0, 8'h0, 1'b1},
        '{ROW_PX, REG_NONE, 13'h0, 8'h0, 8'h80, 8'h80, CHK_PRED, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_WR, REG_PIC_HEIGHT, 13'h1FFF, 8'h0, 8'h0, 8'h0, CHK_DROP, 8'h0, 8'h0, 8'h0, 1'b0},
        '{ROW_PX, REG_NONE, 13'h0, 8'hFF, 8'h80, 8'h80, CHK_GIVEN, 8'hFF, 8'hFF, 8'hFF, 1'b0}
    };

    logic i_clk;
    logic i_rst_n;

    cyr_cfg_if     cfg ();
    cyr_pix_in_if  pix_in ();
    cyr_pix_out_if pix_out ();

    crop_and_ycbcr_to_rgb dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_pix   (pix_in),
        .o_pix   (pix_out)
    );

    // shadow of the block's registers and raster position
    logic [DIM_REG_W-1:0] win_width  = 13'd16;
    logic [DIM_REG_W-1:0] win_height = 13'd16;
    logic [OFF_REG_W-1:0] win_left   = '0;
    logic [OFF_REG_W-1:0] win_right  = '0;
    logic [OFF_REG_W-1:0] win_top    = '0;
    logic [OFF_REG_W-1:0] win_bottom = '0;
    logic                 win_vert4  = 1'b0;
    logic                 win_rgb    = 1'b1;
    int                   col_pos    = 0;
    int                   row_pos    = 0;

    t_rgb pending_pixels [$];
    t_rgb oldest;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_asked     = 0;
    int hold_done      = 0;
    int hold_left      = 0;
    int cycle_count    = 0;
    int n_fed          = 0;
    int n_checked      = 0;
    int n_frame_ends   = 0;
    int n_writes       = 0;
    int n_fail         = 0;

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    function automatic logic [PIX_W-1:0] sat_q8(input int acc);
        if (acc < 0) return 8'd0;
        if ((acc >>> 8) > 255) return 8'hFF;
        return acc[15:8];
    endfunction

    function automatic int limit_dim(input logic [DIM_REG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM_DEF) return MAX_DIM_DEF;
        return int'(v);
    endfunction

    // crop test, conversion or pass-through, and raster step for the current pixel
    function automatic bit crop_and_convert(input t_sample s, output t_rgb r);
        int  w, h, m, lft, rgt, tp, bt, y, u, v;
        bit  kept;
        w    = limit_dim(win_width);
        h    = limit_dim(win_height);
        m    = win_vert4 ? 4 : 2;
        lft  = 2 * int'(win_left);
        rgt  = 2 * int'(win_right);
        tp   = m * int'(win_top);
        bt   = m * int'(win_bottom);
        kept = col_pos >= lft && col_pos + rgt < w && row_pos >= tp && row_pos + bt < h;
        r    = '0;
        if (kept) begin
            if (win_rgb) begin
                y = int'(s.luma) - 16;
                u = int'(s.chroma_blue) - 128;
                v = int'(s.chroma_red) - 128;
                r.comp0 = sat_q8(298 * y + 409 * v);
                r.comp1 = sat_q8(298 * y - 100 * u - 208 * v);
                r.comp2 = sat_q8(298 * y + 516 * u);
            end else begin
                r.comp0 = s.chroma_red;
                r.comp1 = s.luma;
                r.comp2 = s.chroma_blue;
            end
            r.frame_last = (col_pos + rgt + 1 == w) && (row_pos + bt + 1 == h);
        end
        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
        return kept;
    endfunction

    function automatic logic [PIX_W-1:0] any_level();
        case ($urandom_range(9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd16;
            3: return 8'd235;
            4: return 8'd128;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic t_sample any_sample();
        t_sample s;
        s.luma        = any_level();
        s.chroma_blue = any_level();
        s.chroma_red  = any_level();
        return s;
    endfunction

    function automatic logic [DIM_REG_W-1:0] pick_dim();
        case ($urandom_range(11))
            0: return 13'd0;
            1: return 13'($urandom_range(8191, 4097));
            default: return 13'($urandom_range(24, 1));
        endcase
    endfunction

    function automatic logic [OFF_REG_W-1:0] pick_units();
        case ($urandom_range(7))
            0: return 10'($urandom_range(1023));
            1: return 10'd1023;
            default: return 10'($urandom_range(3));
        endcase
    endfunction

    task automatic report_mismatch(input string msg);
        if (n_fail < MAX_PRINTS) $display("mismatch at output %0d: %s", n_checked, msg);
        n_fail++;
    endtask

    task automatic send_pixel(input t_sample s, input t_check chk, input t_rgb given);
        t_rgb r;
        bit   kept;
        while ($urandom_range(99) < send_idle_pct) begin
            pix_in.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_in.valid       <= 1'b1;
        pix_in.luma        <= s.luma;
        pix_in.chroma_blue <= s.chroma_blue;
        pix_in.chroma_red  <= s.chroma_red;
        do @(posedge i_clk); while (pix_in.ready !== 1'b1);
        kept = crop_and_convert(s, r);
        case (chk)
            CHK_GIVEN: pending_pixels.push_back(given);
            CHK_PRED:  if (kept) pending_pixels.push_back(r);
            default: ;
        endcase
        n_fed++;
        @(negedge i_clk);
    endtask

    task automatic wait_idle();
        pix_in.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge i_clk); while (cfg.ready !== 1'b1);
        case (idx)
            REG_PIC_WIDTH:   win_width  = val;
            REG_PIC_HEIGHT:  win_height = val;
            REG_CROP_LEFT:   win_left   = val[OFF_REG_W-1:0];
            REG_CROP_RIGHT:  win_right  = val[OFF_REG_W-1:0];
            REG_CROP_TOP:    win_top    = val[OFF_REG_W-1:0];
            REG_CROP_BOTTOM: win_bottom = val[OFF_REG_W-1:0];
            REG_VERT_FOUR:   win_vert4  = val[0];
            REG_RGB_MODE:    win_rgb    = val[0];
            default: ;
        endcase
        n_writes++;
        @(negedge i_clk);
        cfg.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic apply_window(input logic [DIM_REG_W-1:0] w, input logic [DIM_REG_W-1:0] h,
                                input logic [OFF_REG_W-1:0] l, input logic [OFF_REG_W-1:0] r,
                                input logic [OFF_REG_W-1:0] t, input logic [OFF_REG_W-1:0] b,
                                input logic v4, input logic rgb);
        wait_idle();
        write_reg(REG_PIC_WIDTH, w);
        write_reg(REG_PIC_HEIGHT, h);
        write_reg(REG_CROP_LEFT, 13'(l));
        write_reg(REG_CROP_RIGHT, 13'(r));
        write_reg(REG_CROP_TOP, 13'(t));
        write_reg(REG_CROP_BOTTOM, 13'(b));
        write_reg(REG_VERT_FOUR, 13'(v4));
        write_reg(REG_RGB_MODE, 13'(rgb));
    endtask

    // output side: random stalls plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            pix_out.ready <= 1'b0;
            hold_left = hold_left - 1;
        end else if (hold_asked != hold_done) begin
            hold_done = hold_asked;
            hold_left = HOLD_LEN;
            pix_out.ready <= 1'b0;
        end else begin
            pix_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pix_out.valid === 1'b1 && pix_out.ready === 1'b1) begin
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("item %h %h %h with none pending",
                                          pix_out.comp0, pix_out.comp1, pix_out.comp2));
            end else begin
                oldest = pending_pixels.pop_front();
                if (pix_out.comp0 !== oldest.comp0)
                    report_mismatch($sformatf("comp0 %h, want %h", pix_out.comp0, oldest.comp0));
                if (pix_out.comp1 !== oldest.comp1)
                    report_mismatch($sformatf("comp1 %h, want %h", pix_out.comp1, oldest.comp1));
                if (pix_out.comp2 !== oldest.comp2)
                    report_mismatch($sformatf("comp2 %h, want %h", pix_out.comp2, oldest.comp2));
                if (pix_out.frame_last !== oldest.frame_last)
                    report_mismatch($sformatf("frame_last %b, want %b",
                                              pix_out.frame_last, oldest.frame_last));
                if (oldest.frame_last) n_frame_ends++;
                n_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d items pending", cycle_count,
                     pending_pixels.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_sample row_px;
        t_rgb    row_want;

        i_rst_n            = 1'b0;
        pix_in.valid       = 1'b0;
        pix_in.luma        = '0;
        pix_in.chroma_blue = '0;
        pix_in.chroma_red  = '0;
        cfg.valid          = 1'b0;
        cfg.index          = '0;
        cfg.data           = '0;
        pix_out.ready      = 1'b0;

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int k = 0; k < N_STEPS; k++) begin
            if (DIRECTED[k].kind == ROW_WR) begin
                wait_idle();
                write_reg(DIRECTED[k].idx, DIRECTED[k].val);
            end else begin
                row_px.luma         = DIRECTED[k].luma;
                row_px.chroma_blue  = DIRECTED[k].cb;
                row_px.chroma_red   = DIRECTED[k].cr;
                row_want.comp0      = DIRECTED[k].c0;
                row_want.comp1      = DIRECTED[k].c1;
                row_want.comp2      = DIRECTED[k].c2;
                row_want.frame_last = DIRECTED[k].fl;
                send_pixel(row_px, DIRECTED[k].chk, row_want);
            end
        end

        // widest picture with the largest side offsets
        apply_window(13'h1FFF, 13'd2, 10'd1023, 10'd1023, 10'd0, 10'd0, 1'b0, 1'b1);
        repeat (SWEEP_ITEMS) send_pixel(any_sample(), CHK_PRED, '0);
        // tallest picture, one column, largest top offset in four-row units
        apply_window(13'd0, 13'h1FFF, 10'd0, 10'd0, 10'd1023, 10'd0, 1'b1, 1'b0);
        repeat (SWEEP_ITEMS) send_pixel(any_sample(), CHK_PRED, '0);
        // largest top and bottom offsets in two-row units
        apply_window(13'd0, 13'h1FFF, 10'd0, 10'd0, 10'd1023, 10'd1023, 1'b0, 1'b1);
        repeat (SWEEP_ITEMS) send_pixel(any_sample(), CHK_PRED, '0);

        for (int ph = 0; ph < N_PHASES; ph++) begin
            if (ph == 0)
                apply_window(13'd16, 13'd16, 10'd0, 10'd0, 10'd0, 10'd0, 1'b0, 1'b1);
            else
                apply_window(pick_dim(), pick_dim(), pick_units(), pick_units(), pick_units(),
                             pick_units(), 1'($urandom_range(1)), 1'($urandom_range(1)));
            case (ph % 4)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 81;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 81;
                end
                default: begin
                    send_idle_pct  = 13;
                    recv_stall_pct = 13;
                end
            endcase
            // back up the output so the input stalls
            if (ph == 0) hold_asked++;
            for (int i = 0; i < RAND_ITEMS; i++) begin
                if (ph == 5 && i == RAND_ITEMS / 2) wait_idle();
                send_pixel(any_sample(), CHK_PRED, '0);
            end
        end

        wait_idle();
        $display("%0d pixels fed, %0d converted pixels checked, %0d frame ends, %0d reg writes",
                 n_fed, n_checked, n_frame_ends, n_writes);
        $display("crop windows from empty to widest, both vertical units, rgb and pass-through");
        if (n_fail == 0) begin
            $display("SUCCESS");
        end else begin
            $display("%0d mismatches", n_fail);
            $display("FAILURE");
        end
        $finish;
    end

endmodule
